// File: sv/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the status frame receiver
// Receive phases, frame event codes and byte constants.
// ----------------------------------------------------------------------------
package sfr_pkg;

    typedef enum logic [1:0] {
        PH_SYNC = 2'd0,
        PH_ADDR = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } rx_phase_t;

    typedef logic [2:0] frame_event_t;

    localparam frame_event_t EV_NONE    = 3'd0;
    localparam frame_event_t EV_IGNORED = 3'd1;
    localparam frame_event_t EV_ACK     = 3'd2;
    localparam frame_event_t EV_ARRIVAL = 3'd3;
    localparam frame_event_t EV_BADSUM  = 3'd4;

    localparam logic [7:0] SYNC_BYTE     = 8'hFF;
    localparam logic [7:0] COUNT_MAX     = 8'hFF;
    localparam logic [7:0] LEN_ACK       = 8'd1;
    localparam logic [7:0] LEN_ARRIVAL   = 8'd3;
    localparam logic [7:0] REPLY_ADDR_RST = 8'h4A;

endpackage

// File: sv/status_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// status_frame_receiver_core: serial status frame decoder
// Path from accepted byte to result word: input reg, then result reg.
// Throughput: one byte per cycle unless out_stall holds the result register.
// Reset: asynchronous, active low; phase to sync wait, flags cleared,
// reply address back to 0x4A. No clearing pass.
// ----------------------------------------------------------------------------
module status_frame_receiver_core
    import sfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // byte input
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    // result output
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] frame_event,
    output logic [7:0] frame_address,
    output logic       ack_flag,
    output logic       arrived_flag,
    // reply address write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic [7:0]   reply_addr_reg;

    logic         in_vld_reg;
    logic [7:0]   in_byte_reg;

    rx_phase_t    phase_reg, phase_next;
    logic [6:0]   sum_reg, sum_next;
    logic [7:0]   count_reg, count_next;
    logic [7:0]   addr_reg, addr_next;
    logic [7:0]   len_reg, len_next;
    logic [7:0]   pay0_reg, pay0_next;
    logic [7:0]   pay1_reg, pay1_next;
    logic         ack_seen_reg, ack_seen_next;
    logic         arrived_reg, arrived_next;
    frame_event_t event_next;

    logic         out_vld_reg;
    frame_event_t out_event_reg;
    logic [7:0]   out_addr_reg;
    logic         out_ack_reg;
    logic         out_arrived_reg;

    logic         out_load;
    logic         step;
    logic [6:0]   sum_add;

    assign out_load  = !out_vld_reg || !out_stall;
    assign step      = in_vld_reg && out_load;
    assign in_stall  = in_vld_reg && !out_load;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_addr_reg <= REPLY_ADDR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            reply_addr_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    assign sum_add = sum_reg + in_byte_reg[6:0];

    // frame state update for one byte
    always_comb
    begin
        phase_next    = phase_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        pay0_next     = pay0_reg;
        pay1_next     = pay1_reg;
        ack_seen_next = ack_seen_reg;
        arrived_next  = arrived_reg;
        event_next    = EV_NONE;
        if (phase_reg == PH_SYNC)
        begin
            if (in_byte_reg == SYNC_BYTE)
            begin
                phase_next = PH_ADDR;
            end
        end
        else if (in_byte_reg == SYNC_BYTE)
        begin
            phase_next = PH_ADDR;
        end
        else
        begin
            case (phase_reg)
                PH_ADDR:
                begin
                    count_next = 8'd1;
                    addr_next  = in_byte_reg;
                    sum_next   = in_byte_reg[6:0];
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next   = in_byte_reg;
                    sum_next   = sum_add;
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    if (count_reg == len_reg)
                    begin
                        phase_next = PH_SYNC;
                        // checksum byte above 0x7F never matches
                        if ({1'b0, sum_reg} != in_byte_reg)
                        begin
                            event_next = EV_BADSUM;
                        end
                        else if (addr_reg != reply_addr_reg)
                        begin
                            event_next = EV_IGNORED;
                        end
                        else if (len_reg == LEN_ACK)
                        begin
                            ack_seen_next = 1'b1;
                            event_next    = EV_ACK;
                        end
                        else if (len_reg == LEN_ARRIVAL)
                        begin
                            arrived_next = (pay0_reg | pay1_reg) != 8'd0;
                            event_next   = EV_ARRIVAL;
                        end
                        else
                        begin
                            event_next = EV_IGNORED;
                        end
                    end
                    else
                    begin
                        if (count_reg == 8'd1)
                        begin
                            pay0_next = in_byte_reg;
                        end
                        else if (count_reg == 8'd2)
                        begin
                            pay1_next = in_byte_reg;
                        end
                        sum_next = sum_add;
                        // length zero: counter sticks at max
                        if (count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + 8'd1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_SYNC;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SYNC;
            sum_reg      <= 7'd0;
            count_reg    <= 8'd1;
            addr_reg     <= 8'd0;
            len_reg      <= 8'd0;
            pay0_reg     <= 8'd0;
            pay1_reg     <= 8'd0;
            ack_seen_reg <= 1'b0;
            arrived_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            addr_reg     <= addr_next;
            len_reg      <= len_next;
            pay0_reg     <= pay0_next;
            pay1_reg     <= pay1_next;
            ack_seen_reg <= ack_seen_next;
            arrived_reg  <= arrived_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_event_reg   <= event_next;
            out_addr_reg    <= addr_next;
            out_ack_reg     <= ack_seen_next;
            out_arrived_reg <= arrived_next;
        end
    end

    assign out_valid     = out_vld_reg;
    assign frame_event   = out_event_reg;
    assign frame_address = out_addr_reg;
    assign ack_flag      = out_ack_reg;
    assign arrived_flag  = out_arrived_reg;

`ifndef SYNTHESIS
    // ack is sticky
    a_ack_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ack_seen_reg |=> ack_seen_reg)
        else $error("ack flag dropped");

    // a frame-ending word leaves the receiver waiting for sync
    a_end_to_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (step && event_next != EV_NONE) |=> (phase_reg == PH_SYNC))
        else $error("frame end did not return to sync wait");

    // stall only while a byte is held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg)
        else $error("stall without a held byte");

    // a held byte is not lost while the result waits
    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> (in_vld_reg && $stable(in_byte_reg)))
        else $error("held byte changed under stall");
`endif

endmodule
